>>> rtl/core/rbs_pkg.sv
// shared types, constants and helpers for the record table with bubble sort
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

   localparam int CAPACITY = 8;
   localparam int IDX_W    = 3;
   localparam int CNT_W    = 4;
   localparam int NAME_W   = 64;
   localparam int TOTAL_W  = 10;
   localparam int AVG_W    = 16;

   // floor(t*256/3) == (t * AVG_RECIP) >> AVG_SHIFT for t <= 765
   localparam logic [17:0] AVG_RECIP = 18'd174763;
   localparam int          AVG_SHIFT = 11;
   localparam int          PROD_W    = 28;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DUMP   = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_SORT   = 3'd4;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [7:0]        a;
      logic [7:0]        b;
      logic [7:0]        c;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] slot;
      rec_type          rec;
      logic [CNT_W-1:0] entries;
      logic             last;
   } item_type;

   function automatic logic [TOTAL_W-1:0] rec_total(input rec_type r);
      rec_total = TOTAL_W'(r.a) + TOTAL_W'(r.b) + TOTAL_W'(r.c);
   endfunction

   function automatic item_type mk_blank(input logic [1:0] status,
                                         input logic [CNT_W-1:0] entries);
      item_type it;
      it         = '0;
      it.status  = status;
      it.entries = entries;
      it.last    = 1'b1;
      mk_blank   = it;
   endfunction

   function automatic item_type mk_rec(input rec_type r, input logic [IDX_W-1:0] slot,
                                       input logic [CNT_W-1:0] entries,
                                       input logic last);
      item_type it;
      it.status  = STS_OK;
      it.slot    = slot;
      it.rec     = r;
      it.entries = entries;
      it.last    = last;
      mk_rec     = it;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/rbs_ram.sv
// generic single-write, single-read synchronous ram with a registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rbs_ram #(
   parameter int WIDTH = 88,
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/rbs_ctrl.sv
// sequencer for insert, dump, search, remove and bubble sort over the record ram
// depends on rbs_pkg and rbs_ram
`timescale 1ns / 1ps
`default_nettype none

module rbs_ctrl
   import rbs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [95:0]      req_tdata,
   input  wire logic [2:0]       req_tuser,
   input  wire logic             out_free,
   output logic                  emit_valid,
   output item_type              emit_item
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_EMIT     = 3'd2;
   localparam logic [2:0] ST_SHIFT    = 3'd3;
   localparam logic [2:0] ST_SHIFT_WR = 3'd4;
   localparam logic [2:0] ST_SORT_LD  = 3'd5;
   localparam logic [2:0] ST_SORT_CMP = 3'd6;
   localparam logic [2:0] ST_SORT_END = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        ret_ff, ret_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  pass_ff, pass_in;
   logic [2:0]        op_ff, op_in;
   logic [NAME_W-1:0] key_ff, key_in;
   logic              desc_ff, desc_in;
   rec_type           cur_ff, cur_in;
   item_type          item_ff, item_in;

   logic              rd_en, wr_en;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   rec_type           rd_rec, wr_rec, in_rec;
   logic [REC_W-1:0]  rd_data;
   logic [IDX_W-1:0]  idx_nx;
   logic              last_idx;
   logic              swap;
   logic [TOTAL_W-1:0] tot_cur, tot_nx;

   rbs_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_rec    = rec_type'(rd_data);
   assign in_rec    = '{name: req_tdata[63:0], a: req_tdata[71:64],
                        b: req_tdata[79:72], c: req_tdata[87:80]};
   assign idx_nx    = idx_ff + 1'b1;
   assign last_idx  = (({1'b0, idx_ff} + CNT_W'(1)) == cnt_ff);
   assign tot_cur   = rec_total(cur_ff);
   assign tot_nx    = rec_total(rd_rec);
   assign swap      = desc_ff ? (tot_cur < tot_nx) : (tot_cur > tot_nx);
   assign emit_item = item_ff;

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      pass_in    = pass_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      desc_in    = desc_ff;
      cur_in     = cur_ff;
      item_in    = item_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_rec     = cur_ff;
      emit_valid = 1'b0;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               key_in  = req_tdata[63:0];
               desc_in = req_tdata[88];
               ret_in  = ST_IDLE;
               idx_in  = '0;
               pass_in = '0;
               unique case (req_tuser)
                  OP_INSERT: begin
                     state_in = ST_EMIT;
                     if (cnt_ff == CNT_W'(CAPACITY)) begin
                        item_in = mk_blank(STS_FULL, cnt_ff);
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[IDX_W-1:0];
                        wr_rec  = in_rec;
                        cnt_in  = cnt_ff + 1'b1;
                        item_in = mk_rec(in_rec, cnt_ff[IDX_W-1:0], cnt_ff + 1'b1, 1'b1);
                     end
                  end
                  OP_DUMP, OP_SEARCH, OP_REMOVE: begin
                     if (cnt_ff == '0) begin
                        item_in  = mk_blank((req_tuser == OP_DUMP) ? STS_EMPTY
                                                                   : STS_NOT_FOUND, cnt_ff);
                        state_in = ST_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_SORT: begin
                     if (cnt_ff < CNT_W'(2)) begin
                        item_in  = mk_blank(STS_OK, cnt_ff);
                        state_in = ST_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_SORT_LD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_DUMP) begin
               item_in  = mk_rec(rd_rec, idx_ff, cnt_ff, last_idx);
               ret_in   = last_idx ? ST_IDLE : ST_SCAN;
               state_in = ST_EMIT;
            end else if (rd_rec.name == key_ff) begin
               state_in = ST_EMIT;
               if (op_ff == OP_REMOVE) begin
                  cnt_in  = cnt_ff - 1'b1;
                  item_in = mk_rec(rd_rec, idx_ff, cnt_ff - 1'b1, 1'b1);
                  ret_in  = ST_SHIFT;
               end else begin
                  item_in = mk_rec(rd_rec, idx_ff, cnt_ff, 1'b1);
               end
            end else if (last_idx) begin
               item_in  = mk_blank(STS_NOT_FOUND, cnt_ff);
               state_in = ST_EMIT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_nx;
               idx_in  = idx_nx;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit_valid = 1'b1;
               state_in   = ret_ff;
               if (ret_ff == ST_SCAN) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_nx;
                  idx_in  = idx_nx;
               end
            end
         end
         ST_SHIFT: begin
            if ({1'b0, idx_ff} < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_nx;
               state_in = ST_SHIFT_WR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_rec   = rd_rec;
            idx_in   = idx_nx;
            state_in = ST_SHIFT;
         end
         ST_SORT_LD: begin
            cur_in   = rd_rec;
            rd_en    = 1'b1;
            rd_addr  = idx_nx;
            idx_in   = idx_nx;
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - 1'b1;
            wr_rec  = swap ? rd_rec : cur_ff;
            if (!swap) begin
               cur_in = rd_rec;
            end
            if (last_idx) begin
               state_in = ST_SORT_END;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_nx;
               idx_in  = idx_nx;
            end
         end
         ST_SORT_END: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_rec  = cur_ff;
            if (({1'b0, pass_ff} + CNT_W'(2)) >= cnt_ff) begin
               item_in  = mk_blank(STS_OK, cnt_ff);
               ret_in   = ST_IDLE;
               state_in = ST_EMIT;
            end else begin
               pass_in  = pass_ff + 1'b1;
               idx_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_SORT_LD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ret_ff   <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pass_ff <= pass_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      desc_ff <= desc_in;
      cur_ff  <= cur_in;
      item_ff <= item_in;
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("record count above capacity");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> out_free)
      else $error("transaction emitted into a busy output stage");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_INSERT &&
       cnt_ff != CNT_W'(CAPACITY)) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("insert did not grow the table");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != ST_IDLE) |-> ({1'b0, wr_addr} < cnt_ff + 1'b1))
      else $error("write beyond the filled slots");
`endif

endmodule

`default_nettype wire

>>> rtl/core/rbs_out.sv
// result output register with total and fixed point average of the record
// depends on rbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbs_out
   import rbs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          emit_valid,
   input  item_type           emit_item,
   output logic               out_free,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);

   logic               valid_ff, valid_in;
   item_type           item_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [PROD_W-1:0]  prod;
   logic [AVG_W-1:0]   avg;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (emit_valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         item_ff  <= emit_item;
         total_ff <= rec_total(emit_item.rec);
      end
   end

   assign prod = PROD_W'(total_ff) * PROD_W'(AVG_RECIP);
   assign avg  = prod[AVG_SHIFT +: AVG_W];

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = item_ff.status;
   assign rsp_tlast  = item_ff.last;
   assign rsp_tdata  = {7'd0, item_ff.entries, avg, total_ff, item_ff.rec.c,
                        item_ff.rec.b, item_ff.rec.a, item_ff.rec.name, item_ff.slot};

endmodule

`default_nettype wire

>>> rtl/core/record_table_with_bubble_sort_top.sv
// top level of the record table with bubble sort
// depends on rbs_pkg, rbs_ctrl and rbs_out
`timescale 1ns / 1ps
`default_nettype none

// Holds up to eight records (64-bit name, three 8-bit scores) in one synchronous
// ram and serves one transaction at a time. Search and remove scan the slots in
// order, remove then moves each later record down one slot, dump emits one
// result per record, and sort runs bubble passes in which each compare-swap step
// reads the next record on the read port while the previous one is written back
// on the write port.
// Results leave through an output register, so an idle block takes the next
// transaction while the last result still waits.
module record_table_with_bubble_sort_top
   import rbs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // name_key[63:0], score_a[71:64], score_b[79:72], score_c[87:80], descending[88]
   input  wire logic [95:0]  req_tdata,
   // op[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // slot[2:0], rec_name[66:3], rec_a[74:67], rec_b[82:75], rec_c[90:83],
   // rec_total[100:91], rec_average[116:101], entries[120:117]
   output logic [127:0]      rsp_tdata,
   // status[1:0]
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   logic     out_free;
   logic     emit_valid;
   item_type emit_item;

   rbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_item  (emit_item)
   );

   rbs_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit_valid),
      .emit_item  (emit_item),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> tb/record_table_with_bubble_sort_top_tb.sv
// self-checking testbench for record_table_with_bubble_sort_top
// depends on rbs_pkg and the block rtl; drives directed and random ops and checks every result transaction
`timescale 1ns / 1ps

module record_table_with_bubble_sort_top_tb;
   import rbs_pkg::*;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] name;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic        desc;
   } op_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  slot;
      logic [63:0] name;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [9:0]  total;
      logic [15:0] avg;
      logic [3:0]  entries;
      logic        last;
   } rsp_type;

   localparam int WATCHDOG = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   op_type  pending_ops[$];
   rsp_type expected_rsps[$];
   logic [63:0] tbl_name[CAPACITY];
   logic [7:0]  tbl_a[CAPACITY];
   logic [7:0]  tbl_b[CAPACITY];
   logic [7:0]  tbl_c[CAPACITY];
   int          tbl_fill = 0;
   int          error_count = 0;
   int          idle_cycles = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   bit          stim_done = 1'b0;
   bit          hold_req = 1'b0;
   bit          req_taken = 1'b0;
   bit          rsp_taken = 1'b0;
   logic [63:0] used_names[$];

   record_table_with_bubble_sort_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int slot_total(int i);
      return int'(tbl_a[i]) + int'(tbl_b[i]) + int'(tbl_c[i]);
   endfunction

   function automatic rsp_type record_rsp(int i, bit fin);
      rsp_type r;
      int t;
      t = slot_total(i);
      r.status = STS_OK;
      r.slot = 3'(i);
      r.name = tbl_name[i];
      r.a = tbl_a[i];
      r.b = tbl_b[i];
      r.c = tbl_c[i];
      r.total = 10'(t);
      r.avg = 16'((t * 256) / 3);
      r.entries = 4'(tbl_fill);
      r.last = fin;
      return r;
   endfunction

   function automatic rsp_type blank_rsp(logic [1:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.entries = 4'(tbl_fill);
      r.last = 1'b1;
      return r;
   endfunction

   function automatic int find_slot(logic [63:0] key);
      for (int i = 0; i < tbl_fill; i++)
         if (tbl_name[i] == key) return i;
      return -1;
   endfunction

   task automatic predict_table_op(op_type t);
      int hit;
      rsp_type r;
      logic [63:0] n;
      logic [7:0] s;
      bit sw;
      case (t.op)
         OP_INSERT: begin
            if (tbl_fill >= CAPACITY) expected_rsps.push_back(blank_rsp(STS_FULL));
            else begin
               tbl_name[tbl_fill] = t.name;
               tbl_a[tbl_fill] = t.a;
               tbl_b[tbl_fill] = t.b;
               tbl_c[tbl_fill] = t.c;
               tbl_fill++;
               expected_rsps.push_back(record_rsp(tbl_fill - 1, 1'b1));
            end
         end
         OP_DUMP: begin
            if (tbl_fill == 0) expected_rsps.push_back(blank_rsp(STS_EMPTY));
            else for (int i = 0; i < tbl_fill; i++)
               expected_rsps.push_back(record_rsp(i, i + 1 == tbl_fill));
         end
         OP_SEARCH, OP_REMOVE: begin
            hit = find_slot(t.name);
            if (hit < 0) expected_rsps.push_back(blank_rsp(STS_NOT_FOUND));
            else begin
               r = record_rsp(hit, 1'b1);
               if (t.op == OP_REMOVE) begin
                  for (int i = hit; i + 1 < tbl_fill; i++) begin
                     tbl_name[i] = tbl_name[i + 1];
                     tbl_a[i] = tbl_a[i + 1];
                     tbl_b[i] = tbl_b[i + 1];
                     tbl_c[i] = tbl_c[i + 1];
                  end
                  tbl_fill--;
                  r.entries = 4'(tbl_fill);
               end
               expected_rsps.push_back(r);
            end
         end
         OP_SORT: begin
            for (int i = 0; i < tbl_fill; i++)
               for (int j = 0; j + 1 < tbl_fill; j++) begin
                  sw = t.desc ? (slot_total(j) < slot_total(j + 1))
                              : (slot_total(j) > slot_total(j + 1));
                  if (sw) begin
                     n = tbl_name[j]; tbl_name[j] = tbl_name[j + 1]; tbl_name[j + 1] = n;
                     s = tbl_a[j]; tbl_a[j] = tbl_a[j + 1]; tbl_a[j + 1] = s;
                     s = tbl_b[j]; tbl_b[j] = tbl_b[j + 1]; tbl_b[j + 1] = s;
                     s = tbl_c[j]; tbl_c[j] = tbl_c[j + 1]; tbl_c[j + 1] = s;
                  end
               end
            expected_rsps.push_back(blank_rsp(STS_OK));
         end
         default: ;
      endcase
   endtask

   function automatic op_type mk_op(logic [2:0] op, logic [63:0] name, logic [7:0] a,
                                    logic [7:0] b, logic [7:0] c, logic desc);
      op_type t;
      t.op = op; t.name = name; t.a = a; t.b = b; t.c = c; t.desc = desc;
      return t;
   endfunction

   function automatic logic [63:0] pick_name();
      int r;
      r = $urandom_range(0, 9);
      if (used_names.size() > 0 && r < 4)
         return used_names[$urandom_range(0, used_names.size() - 1)];
      if (r < 7) return 64'($urandom_range(0, 5));
      return {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] pick_score();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      if (r < 5) return 8'($urandom_range(0, 3) * 20);
      return 8'($urandom);
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken || !req_tvalid) begin
            if (req_taken) begin
               req_taken = 1'b0;
               req_gap = gap_len();
            end
            if (req_gap > 0 || hold_req || pending_ops.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_ops[0].op;
               req_tdata <= {7'b0, pending_ops[0].desc, pending_ops[0].c,
                             pending_ops[0].b, pending_ops[0].a, pending_ops[0].name};
            end
         end
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_gap = gap_len();
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready) begin
            predict_table_op(pending_ops.pop_front());
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            got.status = rsp_tuser;
            got.slot = rsp_tdata[2:0];
            got.name = rsp_tdata[66:3];
            got.a = rsp_tdata[74:67];
            got.b = rsp_tdata[82:75];
            got.c = rsp_tdata[90:83];
            got.total = rsp_tdata[100:91];
            got.avg = rsp_tdata[116:101];
            got.entries = rsp_tdata[120:117];
            got.last = rsp_tlast;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, got);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  error_count++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("record_table_with_bubble_sort_top_tb: errors");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_ops.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      op_type t;
      int r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed
      pending_ops.push_back(mk_op(OP_DUMP, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_SEARCH, 64'h1, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_REMOVE, 64'h1, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_SORT, 0, 0, 0, 0, 1));
      pending_ops.push_back(mk_op(OP_INSERT, 64'hffff_ffff_ffff_ffff, 8'hff, 8'hff, 8'hff, 1));
      pending_ops.push_back(mk_op(OP_SORT, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_INSERT, 64'h0, 8'h00, 8'h00, 8'h00, 0));
      pending_ops.push_back(mk_op(OP_INSERT, 64'h4142, 8'h10, 8'h20, 8'h30, 0));
      pending_ops.push_back(mk_op(OP_INSERT, 64'h4142, 8'h30, 8'h20, 8'h10, 1));
      pending_ops.push_back(mk_op(OP_INSERT, 64'h5555_aaaa_5555_aaaa, 8'h01, 8'h00, 8'h00, 0));
      pending_ops.push_back(mk_op(OP_INSERT, 64'haaaa_5555_aaaa_5555, 8'h80, 8'h7f, 8'h01, 1));
      pending_ops.push_back(mk_op(OP_INSERT, 64'h7, 8'h02, 8'h00, 8'h00, 0));
      pending_ops.push_back(mk_op(OP_INSERT, 64'h8, 8'h00, 8'h00, 8'h01, 0));
      pending_ops.push_back(mk_op(OP_INSERT, 64'h9, 8'h55, 8'haa, 8'h00, 0));
      pending_ops.push_back(mk_op(OP_DUMP, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(3'd5, 64'h9, 1, 1, 1, 1));
      pending_ops.push_back(mk_op(3'd7, 64'h9, 1, 1, 1, 1));
      pending_ops.push_back(mk_op(OP_SORT, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_DUMP, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_SORT, 0, 0, 0, 0, 1));
      pending_ops.push_back(mk_op(OP_DUMP, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_SEARCH, 64'h4142, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_REMOVE, 64'h4142, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_REMOVE, 64'h3, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_DUMP, 0, 0, 0, 0, 0));
      used_names = '{64'h0, 64'h4142, 64'h7, 64'h9, 64'hffff_ffff_ffff_ffff};
      // wait until everything has drained, then hold the sender off
      wait_drained();
      hold_req = 1'b1;
      repeat (20) @(posedge clock);
      hold_req = 1'b0;
      for (int k = 0; k < 145; k++) begin
         r = $urandom_range(0, 99);
         t.name = pick_name();
         t.a = pick_score();
         t.b = pick_score();
         t.c = pick_score();
         t.desc = 1'($urandom_range(0, 1));
         if (r < 35) t.op = OP_INSERT;
         else if (r < 50) t.op = OP_DUMP;
         else if (r < 65) t.op = OP_SEARCH;
         else if (r < 82) t.op = OP_REMOVE;
         else if (r < 96) t.op = OP_SORT;
         else t.op = 3'($urandom_range(5, 7));
         if (t.op == OP_INSERT) used_names.push_back(t.name);
         pending_ops.push_back(t);
      end
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("record_table_with_bubble_sort_top_tb: clean");
      else $display("record_table_with_bubble_sort_top_tb: errors");
      $finish;
   end

endmodule
